>>> hdl/tts_pkg.sv
`timescale 1ns / 1ps

package tts_pkg;

    localparam int TAG_W = 31;
    localparam int CNT_W = 3;
    localparam int SLOT_W = 3;

    localparam logic [CNT_W-1:0] COUNT_MAX = CNT_W'(4);
    localparam logic [CNT_W-1:0] COUNT_DONE = CNT_W'(3);
    localparam logic [CNT_W-1:0] COUNT_FIRST = CNT_W'(1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_VICTIM,
        S_UPDATE
    } t_state;

    typedef struct packed {
        logic load;
        logic check;
        logic update;
    } t_cmd;

    typedef struct packed {
        logic match;
        logic tree_ready;
        logic out_free;
    } t_status;

    function automatic logic [CNT_W-1:0] f_sat_inc(input logic [CNT_W-1:0] cnt);
        logic [CNT_W-1:0] res;
        res = cnt;
        if (cnt < COUNT_MAX) begin
            res = cnt + CNT_W'(1);
        end
        return res;
    endfunction

endpackage

>>> hdl/time_tagged_slot_cache.sv
`timescale 1ns / 1ps

// channel | valid    | stall    | payload
// in      | i_valid  | o_stall  | i_time_tag
// out     | o_valid  | i_stall  | o_slot, o_hit, o_evicted_tag, o_update_count, o_complete
//
// one item at a time: a hit runs idle, check, update; a miss adds victim before update
// a miss waits for the registered min tree over the slot tags to settle
// after the previous slot write
// synchronous active-low reset clears all slots to tag 0, count 0
// the result sits in an output register; a stalled output holds the next update

module time_tagged_slot_cache #(
    parameter int SLOTS = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [tts_pkg::TAG_W-1:0]  i_time_tag,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [tts_pkg::SLOT_W-1:0] o_slot,
    output logic                       o_hit,
    output logic [tts_pkg::TAG_W-1:0]  o_evicted_tag,
    output logic [tts_pkg::CNT_W-1:0]  o_update_count,
    output logic                       o_complete
);

    tts_pkg::t_cmd    w_cmd;
    tts_pkg::t_status w_status;

    tts_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    tts_datapath #(
        .SLOTS (SLOTS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_time_tag     (i_time_tag),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_slot         (o_slot),
        .o_hit          (o_hit),
        .o_evicted_tag  (o_evicted_tag),
        .o_update_count (o_update_count),
        .o_complete     (o_complete)
    );

endmodule

>>> hdl/tts_ctrl.sv
`timescale 1ns / 1ps

module tts_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  tts_pkg::t_status i_status,
    output tts_pkg::t_cmd   o_cmd
);

    tts_pkg::t_state r_state;
    tts_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tts_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            tts_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_state = tts_pkg::S_CHECK;
                end
            end
            tts_pkg::S_CHECK: begin
                if (i_status.match) begin
                    n_state = tts_pkg::S_UPDATE;
                end else begin
                    n_state = tts_pkg::S_VICTIM;
                end
            end
            tts_pkg::S_VICTIM: begin
                if (i_status.tree_ready) begin
                    n_state = tts_pkg::S_UPDATE;
                end
            end
            tts_pkg::S_UPDATE: begin
                if (i_status.out_free) begin
                    n_state = tts_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = tts_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_stall = 1'b1;
        case (r_state)
            tts_pkg::S_IDLE: begin
                o_stall = 1'b0;
                o_cmd.load = i_valid;
            end
            tts_pkg::S_CHECK: begin
                o_cmd.check = 1'b1;
            end
            tts_pkg::S_VICTIM: begin
                o_cmd = '0;
            end
            tts_pkg::S_UPDATE: begin
                o_cmd.update = i_status.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

>>> hdl/tts_datapath.sv
`timescale 1ns / 1ps

module tts_datapath #(
    parameter int SLOTS = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [tts_pkg::TAG_W-1:0]     i_time_tag,
    input  tts_pkg::t_cmd                 i_cmd,
    output tts_pkg::t_status              o_status,
    input  logic                          i_stall,
    output logic                          o_valid,
    output logic [tts_pkg::SLOT_W-1:0]    o_slot,
    output logic                          o_hit,
    output logic [tts_pkg::TAG_W-1:0]     o_evicted_tag,
    output logic [tts_pkg::CNT_W-1:0]     o_update_count,
    output logic                          o_complete
);

    localparam int LVL = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int LEAVES = 1 << LVL;
    localparam int NODES = 2 * LEAVES - 1;
    localparam int IW = LVL;
    localparam int SW = $clog2(LVL + 1);

    logic [tts_pkg::TAG_W-1:0] r_tags [SLOTS];
    logic [tts_pkg::CNT_W-1:0] r_cnts [SLOTS];

    logic [tts_pkg::TAG_W-1:0] r_tag;
    logic                      r_hit;
    logic [IW-1:0]             r_pos;
    logic [tts_pkg::CNT_W-1:0] r_cnt_old;

    logic [tts_pkg::TAG_W-1:0] r_nt [LEAVES-1];
    logic [IW-1:0]             r_ni [LEAVES-1];
    logic                      r_nv [LEAVES-1];
    logic [SW-1:0]             r_settle;

    logic                      r_o_valid;
    logic [tts_pkg::SLOT_W-1:0] r_o_slot;
    logic                      r_o_hit;
    logic [tts_pkg::TAG_W-1:0] r_o_evicted;
    logic [tts_pkg::CNT_W-1:0] r_o_count;
    logic                      r_o_complete;

    logic                      m_hit;
    logic [IW-1:0]             m_pos;
    logic [tts_pkg::CNT_W-1:0] m_cnt;

    logic [tts_pkg::TAG_W-1:0] w_tag [NODES];
    logic [IW-1:0]             w_idx [NODES];
    logic                      w_vld [NODES];

    logic [IW-1:0]             w_victim;
    logic [tts_pkg::CNT_W-1:0] w_new_cnt;
    logic                      w_out_free;

    // ascending match scan, highest position wins
    always_comb begin
        m_hit = 1'b0;
        m_pos = '0;
        m_cnt = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if (r_tags[i] == r_tag) begin
                m_hit = 1'b1;
                m_pos = IW'(i);
                m_cnt = r_cnts[i];
            end
        end
    end

    // min tree nodes: internal nodes registered, leaves from the slots
    always_comb begin
        for (int k = 0; k < NODES; k++) begin
            w_tag[k] = '0;
            w_idx[k] = '0;
            w_vld[k] = 1'b0;
        end
        for (int k = 0; k < LEAVES - 1; k++) begin
            w_tag[k] = r_nt[k];
            w_idx[k] = r_ni[k];
            w_vld[k] = r_nv[k];
        end
        for (int j = 0; j < SLOTS; j++) begin
            w_tag[LEAVES - 1 + j] = r_tags[j];
            w_idx[LEAVES - 1 + j] = IW'(j);
            w_vld[LEAVES - 1 + j] = 1'b1;
        end
    end

    // ties go to the higher position (right child)
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < LEAVES - 1; k++) begin
            if (w_vld[2*k+1] && (!w_vld[2*k+2] || (w_tag[2*k+1] < w_tag[2*k+2]))) begin
                r_nt[k] <= w_tag[2*k+1];
                r_ni[k] <= w_idx[2*k+1];
                r_nv[k] <= 1'b1;
            end else begin
                r_nt[k] <= w_tag[2*k+2];
                r_ni[k] <= w_idx[2*k+2];
                r_nv[k] <= w_vld[2*k+2];
            end
        end
    end

    assign w_victim = r_ni[0];
    assign w_new_cnt = r_hit ? tts_pkg::f_sat_inc(r_cnt_old) : tts_pkg::COUNT_FIRST;
    assign w_out_free = !r_o_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle <= SW'(LVL);
        end else if (i_cmd.update) begin
            r_settle <= SW'(LVL);
        end else if (r_settle != '0) begin
            r_settle <= r_settle - SW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_tag <= i_time_tag;
        end
        if (i_cmd.check) begin
            r_hit <= m_hit;
            r_pos <= m_pos;
            r_cnt_old <= m_cnt;
        end
    end

    for (genvar i = 0; i < SLOTS; i++) begin : g_slot
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_tags[i] <= '0;
                r_cnts[i] <= '0;
            end else if (i_cmd.update) begin
                if (r_hit) begin
                    if (r_pos == IW'(i)) begin
                        r_cnts[i] <= w_new_cnt;
                    end
                end else if (i == SLOTS - 1) begin
                    r_tags[i] <= r_tag;
                    r_cnts[i] <= w_new_cnt;
                end else if (w_victim <= IW'(i)) begin
                    r_tags[i] <= r_tags[(i < SLOTS - 1) ? i + 1 : i];
                    r_cnts[i] <= r_cnts[(i < SLOTS - 1) ? i + 1 : i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.update) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_o_slot <= r_hit ? tts_pkg::SLOT_W'(r_pos) : tts_pkg::SLOT_W'(SLOTS - 1);
            r_o_hit <= r_hit;
            r_o_evicted <= r_hit ? '0 : r_nt[0];
            r_o_count <= w_new_cnt;
            r_o_complete <= (w_new_cnt == tts_pkg::COUNT_DONE);
        end
    end

    assign o_status.match = m_hit;
    assign o_status.tree_ready = (r_settle == '0);
    assign o_status.out_free = w_out_free;

    assign o_valid = r_o_valid;
    assign o_slot = r_o_slot;
    assign o_hit = r_o_hit;
    assign o_evicted_tag = r_o_evicted;
    assign o_update_count = r_o_count;
    assign o_complete = r_o_complete;

endmodule
